>>> design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define CHK_ALWAYS(name, clk, rstn, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// When pre holds, post must hold on the next clock.
`define CHK_NEXT(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

>>> design/dtmf_pkg.sv
package dtmf_pkg;

    localparam int SAMPLE_RATE_DEF = 16000;
    localparam int SINE_DEPTH_DEF  = 1024;
    localparam int PHASE_BITS_DEF  = 32;

    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 21;
    localparam int MS_W       = 16;
    localparam int LEVEL_W    = 7;
    localparam int TAB_W      = 15;
    localparam int MAG_W      = 22;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 7'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_RST    = 7'd40;
    localparam logic [MS_W-1:0]    TONE_MS_RST  = 16'd100;
    localparam logic [MS_W-1:0]    PAUSE_MS_RST = 16'd0;
    localparam int                 MS_PER_S     = 1000;

    localparam logic [TAB_W-1:0] TAB_FULL    = 15'd32767;
    localparam logic [63:0]      HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0]      Q30_ONE     = 64'd1073741824;

    // floor(m / 100) == (m * DIV100_RECIP) >> DIV100_SHIFT for m below 2^22
    localparam int               RECIP_W      = 23;
    localparam int               DIV100_SHIFT = 29;
    localparam logic [RECIP_W-1:0] DIV100_RECIP = 23'd5368710;

    localparam int JOB_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    typedef struct packed {
        logic tone;
        logic accepted;
        logic busy;
        logic last;
    } job_flags_t;

    typedef struct packed {
        logic               busy;
        logic [COUNT_W-1:0] tone_cnt;
        logic [COUNT_W-1:0] pause_cnt;
        logic [LEVEL_W-1:0] level;
    } cfg_stat_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       accepted;
        logic                       busy;
        logic                       last;
    } result_t;

endpackage

>>> design/dtmf_fifo.sv
module dtmf_fifo
    import dtmf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;

endmodule

>>> design/dtmf_cfg.sv
module dtmf_cfg
    import dtmf_pkg::*;
#(
    parameter int SAMPLE_RATE = SAMPLE_RATE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_stat_t             stat
);

    localparam logic [CFG_IDX_W-1:0] CFG_TONE_MS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL    = 2'd2;

    // rate = whole * 1000 + frac, so rate * ms / 1000 = whole * ms + frac * ms / 1000
    localparam int RATE_WHOLE = SAMPLE_RATE / MS_PER_S;
    localparam int RATE_FRAC  = SAMPLE_RATE % MS_PER_S;
    localparam int BASE_W     = 23;
    localparam int PART_W     = 26;

    // floor(m / 1000) == (m * DIV1000_RECIP) >> DIV1000_SHIFT for m below 2^26
    localparam int                   DIV1000_W     = 27;
    localparam int                   DIV1000_SHIFT = 36;
    localparam logic [DIV1000_W-1:0] DIV1000_RECIP = 27'd68719477;
    localparam int                   PROD_W        = PART_W + DIV1000_W;

    localparam logic [63:0] TONE_RST_Q  =
        (64'(SAMPLE_RATE) * 64'(TONE_MS_RST)) / 64'(MS_PER_S);
    localparam logic [63:0] PAUSE_RST_Q =
        (64'(SAMPLE_RATE) * 64'(PAUSE_MS_RST)) / 64'(MS_PER_S);
    localparam logic [COUNT_W-1:0] TONE_CNT_RST  =
        (TONE_RST_Q > 64'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(TONE_RST_Q);
    localparam logic [COUNT_W-1:0] PAUSE_CNT_RST =
        (PAUSE_RST_Q > 64'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(PAUSE_RST_Q);

    logic [COUNT_W-1:0] tone_cnt_reg, tone_cnt_next;
    logic [COUNT_W-1:0] pause_cnt_reg, pause_cnt_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               busy_reg, busy_next;
    logic               tgt_pause_reg, tgt_pause_next;
    logic               stage_reg, stage_next;
    logic [BASE_W-1:0]  base_reg, base_next;
    logic [PART_W-1:0]  part_reg, part_next;
    logic [MS_W-1:0]    frac_reg, frac_next;

    logic               wr;
    logic [PROD_W-1:0]  prod;
    logic [BASE_W-1:0]  total;
    logic [COUNT_W-1:0] quo_sat;

    assign wr      = cfg_valid && !busy_reg;
    assign prod    = PROD_W'(part_reg) * PROD_W'(DIV1000_RECIP);
    assign total   = base_reg + BASE_W'(frac_reg);
    assign quo_sat = (total > BASE_W'(COUNT_MAX)) ? COUNT_MAX : total[COUNT_W-1:0];

    // Sample count = rate * ms / 1000: split on write, divide, then sum and saturate
    always_comb
    begin
        tone_cnt_next  = tone_cnt_reg;
        pause_cnt_next = pause_cnt_reg;
        level_next     = level_reg;
        busy_next      = busy_reg;
        tgt_pause_next = tgt_pause_reg;
        stage_next     = stage_reg;
        base_next      = base_reg;
        part_next      = part_reg;
        frac_next      = frac_reg;
        if (wr)
        begin
            unique case (cfg_index) inside
                CFG_TONE_MS, CFG_PAUSE_MS:
                begin
                    busy_next      = 1'b1;
                    tgt_pause_next = (cfg_index == CFG_PAUSE_MS);
                    stage_next     = 1'b0;
                    base_next      = BASE_W'(RATE_WHOLE) * BASE_W'(cfg_data[MS_W-1:0]);
                    part_next      = PART_W'(RATE_FRAC) * PART_W'(cfg_data[MS_W-1:0]);
                end
                CFG_LEVEL:
                begin
                    level_next = (cfg_data[LEVEL_W-1:0] > LEVEL_MAX) ?
                                 LEVEL_MAX : cfg_data[LEVEL_W-1:0];
                end
                default: ;
            endcase
        end
        else if (busy_reg)
        begin
            if (!stage_reg)
            begin
                frac_next  = prod[DIV1000_SHIFT +: MS_W];
                stage_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b0;
                if (tgt_pause_reg)
                begin
                    pause_cnt_next = quo_sat;
                end
                else
                begin
                    tone_cnt_next = quo_sat;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_cnt_reg  <= TONE_CNT_RST;
            pause_cnt_reg <= PAUSE_CNT_RST;
            level_reg     <= LEVEL_RST;
            busy_reg      <= 1'b0;
            tgt_pause_reg <= 1'b0;
            stage_reg     <= 1'b0;
        end
        else
        begin
            tone_cnt_reg  <= tone_cnt_next;
            pause_cnt_reg <= pause_cnt_next;
            level_reg     <= level_next;
            busy_reg      <= busy_next;
            tgt_pause_reg <= tgt_pause_next;
            stage_reg     <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        part_reg <= part_next;
        frac_reg <= frac_next;
    end

    assign cfg_ready       = !busy_reg;
    assign stat.busy      = busy_reg;
    assign stat.tone_cnt  = tone_cnt_reg;
    assign stat.pause_cnt = pause_cnt_reg;
    assign stat.level     = level_reg;

endmodule

>>> design/dtmf_front.sv
module dtmf_front
    import dtmf_pkg::*;
#(
    parameter int SAMPLE_RATE = SAMPLE_RATE_DEF,
    parameter int PHASE_BITS  = PHASE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic                  kind,
    input  logic [7:0]            digit,
    input  cfg_stat_t             stat,
    output logic                  job_wr,
    output job_flags_t            job_flags,
    output logic [PHASE_BITS-1:0] job_low_phase,
    output logic [PHASE_BITS-1:0] job_high_phase
);

    localparam logic KIND_LOAD = 1'b0;

    function automatic logic [PHASE_BITS-1:0] step_of(input int freq);
        logic [63:0] num;
        num = (64'(freq) << PHASE_BITS) + 64'(SAMPLE_RATE / 2);
        return PHASE_BITS'(num / 64'(SAMPLE_RATE));
    endfunction

    localparam logic [PHASE_BITS-1:0] STEP_697  = step_of(697);
    localparam logic [PHASE_BITS-1:0] STEP_770  = step_of(770);
    localparam logic [PHASE_BITS-1:0] STEP_852  = step_of(852);
    localparam logic [PHASE_BITS-1:0] STEP_941  = step_of(941);
    localparam logic [PHASE_BITS-1:0] STEP_1209 = step_of(1209);
    localparam logic [PHASE_BITS-1:0] STEP_1336 = step_of(1336);
    localparam logic [PHASE_BITS-1:0] STEP_1477 = step_of(1477);
    localparam logic [PHASE_BITS-1:0] STEP_1633 = step_of(1633);

    function automatic logic [PHASE_BITS-1:0] row_step(input logic [7:0] c);
        logic [PHASE_BITS-1:0] s;
        unique case (c) inside
            "1", "2", "3", "a", "A": s = STEP_697;
            "4", "5", "6", "b", "B": s = STEP_770;
            "7", "8", "9", "c", "C": s = STEP_852;
            "*", "0", "#", "d", "D": s = STEP_941;
            default:                 s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [PHASE_BITS-1:0] col_step(input logic [7:0] c);
        logic [PHASE_BITS-1:0] s;
        unique case (c) inside
            "1", "4", "7", "*":                     s = STEP_1209;
            "2", "5", "8", "0":                     s = STEP_1336;
            "3", "6", "9", "#":                     s = STEP_1477;
            "a", "A", "b", "B", "c", "C", "d", "D": s = STEP_1633;
            default:                                s = '0;
        endcase
        return s;
    endfunction

    logic [PHASE_BITS-1:0] low_phase_reg, low_phase_next;
    logic [PHASE_BITS-1:0] high_phase_reg, high_phase_next;
    logic [PHASE_BITS-1:0] low_step_reg, low_step_next;
    logic [PHASE_BITS-1:0] high_step_reg, high_step_next;
    logic [COUNT_W-1:0]    tone_left_reg, tone_left_next;
    logic [COUNT_W-1:0]    pause_left_reg, pause_left_next;

    always_comb
    begin
        low_phase_next  = low_phase_reg;
        high_phase_next = high_phase_reg;
        low_step_next   = low_step_reg;
        high_step_next  = high_step_reg;
        tone_left_next  = tone_left_reg;
        pause_left_next = pause_left_reg;
        job_flags       = '0;
        if (take)
        begin
            if (kind == KIND_LOAD)
            begin
                if (tone_left_reg == '0 && pause_left_reg == '0)
                begin
                    job_flags.accepted = 1'b1;
                    job_flags.busy     = (stat.tone_cnt != '0) || (stat.pause_cnt != '0);
                    low_phase_next     = '0;
                    high_phase_next    = '0;
                    low_step_next      = row_step(digit);
                    high_step_next     = col_step(digit);
                    tone_left_next     = stat.tone_cnt;
                    pause_left_next    = stat.pause_cnt;
                end
                else
                begin
                    job_flags.busy = 1'b1;
                end
            end
            else if (tone_left_reg != '0)
            begin
                // Sample uses the phase before this step
                job_flags.tone  = 1'b1;
                job_flags.last  = (tone_left_reg == COUNT_W'(1)) && (pause_left_reg == '0);
                job_flags.busy  = !job_flags.last;
                low_phase_next  = low_phase_reg + low_step_reg;
                high_phase_next = high_phase_reg + high_step_reg;
                tone_left_next  = tone_left_reg - COUNT_W'(1);
            end
            else if (pause_left_reg != '0)
            begin
                job_flags.last  = (pause_left_reg == COUNT_W'(1));
                job_flags.busy  = !job_flags.last;
                pause_left_next = pause_left_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_phase_reg  <= '0;
            high_phase_reg <= '0;
            low_step_reg   <= '0;
            high_step_reg  <= '0;
            tone_left_reg  <= '0;
            pause_left_reg <= '0;
        end
        else
        begin
            low_phase_reg  <= low_phase_next;
            high_phase_reg <= high_phase_next;
            low_step_reg   <= low_step_next;
            high_step_reg  <= high_step_next;
            tone_left_reg  <= tone_left_next;
            pause_left_reg <= pause_left_next;
        end
    end

    assign job_wr         = take;
    assign job_low_phase  = low_phase_reg;
    assign job_high_phase = high_phase_reg;

endmodule

>>> design/dtmf_back.sv
module dtmf_back
    import dtmf_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
    parameter int PHASE_BITS       = PHASE_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_empty,
    input  job_flags_t                     job_flags,
    input  logic [PHASE_BITS-1:0]          job_low_phase,
    input  logic [PHASE_BITS-1:0]          job_high_phase,
    output logic                           job_rd,
    input  logic [LEVEL_W-1:0]             level,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                           res_wr,
    output result_t                        res_data
);

    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int REST_W = PHASE_BITS - 2;
    localparam int IDXP_W = REST_W + ADDR_W;
    localparam int STAGES = 4;
    localparam int USED_W = $clog2(OUT_DEPTH + STAGES + 1);
    localparam int QPROD_W = MAG_W + RECIP_W;

    localparam logic signed [SAMPLE_W:0] SUM_MAX = 17'sd32767;
    localparam logic signed [SAMPLE_W:0] SUM_MIN = -17'sd32768;

    typedef logic [TAB_W-1:0] rom_t [SINE_TABLE_DEPTH + 1];

    // Quarter-wave Q15 sine, Q30 Taylor series to the x^15 term
    function automatic rom_t build_rom();
        rom_t               r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            x    = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            acc  = $signed(x);
            term = ((x * x2) >> 30) / 64'd6;
            acc  = acc - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            acc  = acc + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            acc  = acc - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            acc  = acc + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            acc  = acc - $signed(term);
            term = ((term * x2) >> 30) / 64'd156;
            acc  = acc + $signed(term);
            term = ((term * x2) >> 30) / 64'd210;
            acc  = acc - $signed(term);
            if (acc < 0)
            begin
                acc = 0;
            end
            if (acc > $signed(Q30_ONE))
            begin
                acc = $signed(Q30_ONE);
            end
            r[k] = TAB_W'(($unsigned(acc) * 64'd32767 + (Q30_ONE >> 1)) >> 30);
        end
        r[SINE_TABLE_DEPTH] = TAB_FULL;
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Stage A: table addresses
    logic              a_valid_reg;
    job_flags_t        a_flags_reg;
    logic [ADDR_W-1:0] a_addr_lo_reg, a_addr_hi_reg;
    logic              a_neg_lo_reg, a_neg_hi_reg;
    // Stage B: table data
    logic              b_valid_reg;
    job_flags_t        b_flags_reg;
    logic [TAB_W-1:0]  b_tab_lo_reg, b_tab_hi_reg;
    logic              b_neg_lo_reg, b_neg_hi_reg;
    // Stage C: scaled by level
    logic              c_valid_reg;
    job_flags_t        c_flags_reg;
    logic [MAG_W-1:0]  c_mag_lo_reg, c_mag_hi_reg;
    logic              c_neg_lo_reg, c_neg_hi_reg;
    // Stage D: divided by one hundred
    logic              d_valid_reg;
    job_flags_t        d_flags_reg;
    logic [TAB_W-1:0]  d_q_lo_reg, d_q_hi_reg;
    logic              d_neg_lo_reg, d_neg_hi_reg;

    logic [USED_W-1:0]    used;
    logic [IDXP_W-1:0]    idxp_lo, idxp_hi;
    logic [ADDR_W-1:0]    idx_lo, idx_hi;
    logic [QPROD_W-1:0]   qp_lo, qp_hi;
    logic signed [SAMPLE_W:0] tone_lo, tone_hi, sum;
    logic signed [SAMPLE_W-1:0] sat;

    // Take a job only when the result queue has room for everything in flight
    assign used   = USED_W'(out_count) +
                    USED_W'($countones({a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg}));
    assign job_rd = !job_empty && (used < USED_W'(OUT_DEPTH));

    assign idxp_lo = IDXP_W'(job_low_phase[REST_W-1:0]) * IDXP_W'(SINE_TABLE_DEPTH);
    assign idxp_hi = IDXP_W'(job_high_phase[REST_W-1:0]) * IDXP_W'(SINE_TABLE_DEPTH);
    assign idx_lo  = idxp_lo[REST_W +: ADDR_W];
    assign idx_hi  = idxp_hi[REST_W +: ADDR_W];

    assign qp_lo = QPROD_W'(c_mag_lo_reg) * QPROD_W'(DIV100_RECIP);
    assign qp_hi = QPROD_W'(c_mag_hi_reg) * QPROD_W'(DIV100_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= job_rd;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // Odd quadrants mirror the index, upper half negates
        a_flags_reg   <= job_flags;
        a_addr_lo_reg <= job_low_phase[PHASE_BITS-2] ?
                         ADDR_W'(SINE_TABLE_DEPTH) - idx_lo : idx_lo;
        a_addr_hi_reg <= job_high_phase[PHASE_BITS-2] ?
                         ADDR_W'(SINE_TABLE_DEPTH) - idx_hi : idx_hi;
        a_neg_lo_reg  <= job_low_phase[PHASE_BITS-1];
        a_neg_hi_reg  <= job_high_phase[PHASE_BITS-1];

        b_flags_reg  <= a_flags_reg;
        b_tab_lo_reg <= SINE_ROM[a_addr_lo_reg];
        b_tab_hi_reg <= SINE_ROM[a_addr_hi_reg];
        b_neg_lo_reg <= a_neg_lo_reg;
        b_neg_hi_reg <= a_neg_hi_reg;

        c_flags_reg  <= b_flags_reg;
        c_mag_lo_reg <= MAG_W'(b_tab_lo_reg) * MAG_W'(level);
        c_mag_hi_reg <= MAG_W'(b_tab_hi_reg) * MAG_W'(level);
        c_neg_lo_reg <= b_neg_lo_reg;
        c_neg_hi_reg <= b_neg_hi_reg;

        d_flags_reg  <= c_flags_reg;
        d_q_lo_reg   <= qp_lo[DIV100_SHIFT +: TAB_W];
        d_q_hi_reg   <= qp_hi[DIV100_SHIFT +: TAB_W];
        d_neg_lo_reg <= c_neg_lo_reg;
        d_neg_hi_reg <= c_neg_hi_reg;
    end

    // Truncation toward zero: divide the magnitude, then apply the sign
    always_comb
    begin
        tone_lo = d_neg_lo_reg ? -$signed({2'b00, d_q_lo_reg}) : $signed({2'b00, d_q_lo_reg});
        tone_hi = d_neg_hi_reg ? -$signed({2'b00, d_q_hi_reg}) : $signed({2'b00, d_q_hi_reg});
        sum     = tone_lo + tone_hi;
        if (sum > SUM_MAX)
        begin
            sat = SUM_MAX[SAMPLE_W-1:0];
        end
        else if (sum < SUM_MIN)
        begin
            sat = SUM_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            sat = sum[SAMPLE_W-1:0];
        end
    end

    assign res_wr            = d_valid_reg;
    assign res_data.sample   = d_flags_reg.tone ? sat : '0;
    assign res_data.accepted = d_flags_reg.accepted;
    assign res_data.busy     = d_flags_reg.busy;
    assign res_data.last     = d_flags_reg.last;

endmodule

>>> design/dtmf_tone_generator.sv
// DTMF dual-tone generator.
// Input queue: push with kind and digit while full is low. kind 0 loads an
// ASCII dial character; kind 1 asks for the next sample. Every input item
// gives exactly one result, in order.
// Result queue: while empty is low, sample, accepted, busy_res and
// last_sample show the oldest result; pop takes it.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 tone_ms, 1 pause_ms,
// 2 tone_level_percent, 3 ignored) and cfg_data. A level write is registered
// directly; a tone_ms or pause_ms write turns milliseconds into a sample count
// by reciprocal multiplication in a divide step and then a sum step, during
// which cfg_ready and full read busy.
// Throughput: one item per cycle while full is low. Each result passes through
// the job queue, address, table, level multiply and divide-by-100 multiply
// registers, then sum and saturate into the result queue.
// When pop stays low the result queue fills, the back end stops taking jobs,
// the four-entry job queue fills and full rises; nothing is dropped.
// Reset: tone_ms 100, pause_ms 0, level 40, no digit playing, both queues
// empty. No clearing pass is needed.
module dtmf_tone_generator
    import dtmf_pkg::*;
#(
    parameter int SAMPLE_RATE      = SAMPLE_RATE_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
    parameter int PHASE_BITS       = PHASE_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       kind,
    input  logic [7:0]                 digit,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic                       accepted,
    output logic                       busy_res,
    output logic                       last_sample,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    localparam int JOB_W = $bits(job_flags_t) + 2 * PHASE_BITS;
    localparam int RES_W = $bits(result_t);

    cfg_stat_t                      stat;
    logic                           take;
    logic                           job_wr, job_rd, job_full, job_empty;
    job_flags_t                     wr_flags, rd_flags;
    logic [PHASE_BITS-1:0]          wr_low, wr_high, rd_low, rd_high;
    logic [JOB_W-1:0]               job_rd_data;
    logic                           res_wr;
    result_t                        res_in, res_out;
    logic [RES_W-1:0]               res_rd_data;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

    assign full = job_full || stat.busy;
    assign take = push && !full;

    dtmf_cfg #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat)
    );

    dtmf_front #(
        .SAMPLE_RATE (SAMPLE_RATE),
        .PHASE_BITS  (PHASE_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .kind           (kind),
        .digit          (digit),
        .stat           (stat),
        .job_wr         (job_wr),
        .job_flags      (wr_flags),
        .job_low_phase  (wr_low),
        .job_high_phase (wr_high)
    );

    dtmf_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_wr),
        .wr_data ({wr_flags, wr_low, wr_high}),
        .rd_en   (job_rd),
        .rd_data (job_rd_data),
        .full    (job_full),
        .empty   (job_empty),
        .count   ()
    );

    assign {rd_flags, rd_low, rd_high} = job_rd_data;

    dtmf_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_empty      (job_empty),
        .job_flags      (rd_flags),
        .job_low_phase  (rd_low),
        .job_high_phase (rd_high),
        .job_rd         (job_rd),
        .level          (stat.level),
        .out_count      (out_count),
        .res_wr         (res_wr),
        .res_data       (res_in)
    );

    dtmf_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_in),
        .rd_en   (pop && !empty),
        .rd_data (res_rd_data),
        .full    (),
        .empty   (empty),
        .count   (out_count)
    );

    assign res_out     = res_rd_data;
    assign sample      = res_out.sample;
    assign accepted    = res_out.accepted;
    assign busy_res    = res_out.busy;
    assign last_sample = res_out.last;

endmodule

>>> design/dtmf_port_chk.sv
`include "assert_macros.svh"

module dtmf_port_chk
(
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic signed [15:0] sample,
    input logic               accepted,
    input logic               busy_res,
    input logic               last_sample
);

    // A taken load never ends a digit
    `CHK_ALWAYS(a_load_not_last, clk, rst_n, empty || !(accepted && last_sample), "load marked last")

    // The final sample of a digit leaves nothing to play
    `CHK_ALWAYS(a_last_idle, clk, rst_n, empty || !last_sample || !busy_res, "last while busy")

    // Accepted loads carry a silent sample
    `CHK_ALWAYS(a_load_silent, clk, rst_n, empty || !accepted || (sample == 16'sd0), "load with sample")

    // A waiting sample stays put until it transfers
    `CHK_NEXT(a_head_holds, clk, rst_n, !empty && !pop, !empty && $stable(sample), "head moved")

endmodule

bind dtmf_tone_generator dtmf_port_chk u_port_chk (.*);
